[rtl/b64d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam int MaxResults = 4;
  localparam int CountW     = $clog2(MaxResults + 1);
  localparam int SlotW      = $clog2(MaxResults);

  // sextet codes beyond the alphabet
  localparam logic [6:0] SYM_PAD = 7'h40;
  localparam logic [6:0] SYM_BAD = 7'h7F;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef struct packed {
    logic [CountW-1:0]               count;
    logic [MaxResults-1:0][1:0]      kind;
    logic [MaxResults-1:0][7:0]      data;
  } bundle_t;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = SYM_BAD;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == CH_PLUS) begin
      v = 7'h3E;
    end else if (c == CH_SLASH) begin
      v = 7'h3F;
    end else if (c == CH_PAD) begin
      v = SYM_PAD;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/b64d_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

module b64d_decode (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       in_char,
  input  wire logic             is_last,
  output b64d_pkg::bundle_t     bundle
);

  logic [1:0]  group_position, group_position_next;
  logic [17:0] sextet_accumulator, sextet_accumulator_next;
  logic [1:0]  pad_count, pad_count_next;
  logic        space_pending, space_pending_next;
  logic        cr_pending, cr_pending_next;
  logic        error_seen, error_seen_next;

  always_comb begin
    logic [6:0]  v;
    logic [23:0] x;
    logic [1:0]  nbytes;
    logic        emit;

    group_position_next     = group_position;
    sextet_accumulator_next = sextet_accumulator;
    pad_count_next          = pad_count;
    space_pending_next      = space_pending;
    cr_pending_next         = cr_pending;
    error_seen_next         = error_seen;
    bundle                  = '0;
    v      = b64d_pkg::sextet_of(in_char);
    x      = {sextet_accumulator, v[5:0]};
    nbytes = 2'd0;
    emit   = 1'b0;

    if (!error_seen) begin
      if (cr_pending) begin
        cr_pending_next = 1'b0;
        if (in_char == b64d_pkg::CH_LF) begin
          space_pending_next = 1'b0;
        end else begin
          error_seen_next = 1'b1;
        end
      end else if (in_char == b64d_pkg::CH_SPACE) begin
        space_pending_next = 1'b1;
      end else if (in_char == b64d_pkg::CH_LF) begin
        space_pending_next = 1'b0;
      end else if (in_char == b64d_pkg::CH_CR) begin
        cr_pending_next    = 1'b1;
        space_pending_next = 1'b0;
      end else if (space_pending) begin
        error_seen_next = 1'b1;
      end else if (v == b64d_pkg::SYM_PAD && pad_count >= 2'd2) begin
        error_seen_next = 1'b1;
      end else if (v == b64d_pkg::SYM_BAD) begin
        error_seen_next = 1'b1;
      end else if (v != b64d_pkg::SYM_PAD && pad_count != 2'd0) begin
        error_seen_next = 1'b1;
      end else begin
        // pad counts as sextet zero
        if (v == b64d_pkg::SYM_PAD) begin
          pad_count_next = pad_count + 2'd1;
        end
        if (group_position != 2'd3) begin
          sextet_accumulator_next = {sextet_accumulator[11:0], v[5:0]};
          group_position_next     = group_position + 2'd1;
        end else begin
          sextet_accumulator_next = '0;
          group_position_next     = 2'd0;
          emit                    = 1'b1;
          nbytes                  = 2'd3 - pad_count_next;
        end
      end
    end

    if (emit) begin
      bundle.count   = b64d_pkg::CountW'(nbytes);
      bundle.kind[0] = b64d_pkg::KIND_DATA;
      bundle.kind[1] = b64d_pkg::KIND_DATA;
      bundle.kind[2] = b64d_pkg::KIND_DATA;
      bundle.data[0] = x[23:16];
      bundle.data[1] = x[15:8];
      bundle.data[2] = x[7:0];
    end

    if (is_last) begin
      // end status goes right after the bytes
      bundle.kind[nbytes] = (error_seen_next || cr_pending_next) ?
                            b64d_pkg::KIND_ERR : b64d_pkg::KIND_OK;
      bundle.data[nbytes] = 8'h00;
      bundle.count        = b64d_pkg::CountW'(nbytes) + b64d_pkg::CountW'(1);
      group_position_next     = '0;
      sextet_accumulator_next = '0;
      pad_count_next          = '0;
      space_pending_next      = 1'b0;
      cr_pending_next         = 1'b0;
      error_seen_next         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position     <= '0;
      sextet_accumulator <= '0;
      pad_count          <= '0;
      space_pending      <= 1'b0;
      cr_pending         <= 1'b0;
      error_seen         <= 1'b0;
    end else if (accept) begin
      group_position     <= group_position_next;
      sextet_accumulator <= sextet_accumulator_next;
      pad_count          <= pad_count_next;
      space_pending      <= space_pending_next;
      cr_pending         <= cr_pending_next;
      error_seen         <= error_seen_next;
    end
  end

  a_pad_range: assert property (@(posedge clk) disable iff (rst)
    pad_count != 2'd3)
    else $error("pad count out of range");

  a_group_empty_after_pad_reset: assert property (@(posedge clk) disable iff (rst)
    accept && is_last |=> group_position == 2'd0 && pad_count == 2'd0 && !error_seen)
    else $error("state not cleared after end of message");

endmodule

`default_nettype wire

[rtl/b64d_serializer.sv]
`timescale 1ns / 1ps
`default_nettype none

module b64d_serializer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire b64d_pkg::bundle_t bundle_in,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             kind,
  output logic [7:0]             data_byte,
  output logic                   last_of_run
);

  b64d_pkg::bundle_t              bundle;
  b64d_pkg::bundle_t              spare;
  logic                           bval;
  logic                           sval;
  logic [b64d_pkg::SlotW-1:0]     idx;
  logic                           take;
  logic                           at_last;
  logic                           advance;

  assign at_last     = b64d_pkg::CountW'(idx) == (bundle.count - b64d_pkg::CountW'(1));
  assign take        = bval && !out_stall;
  assign advance     = !bval || (take && at_last);
  // a new request may come in as long as the spare bundle is empty
  assign free        = !sval;
  assign out_valid   = bval;
  assign kind        = bundle.kind[idx];
  assign data_byte   = bundle.data[idx];
  assign last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      bval <= 1'b0;
      sval <= 1'b0;
      idx  <= '0;
    end else if (advance) begin
      // refill from the spare first, else straight from the decoder
      bval <= sval || load;
      sval <= 1'b0;
      idx  <= '0;
    end else begin
      if (take) begin
        idx <= idx + b64d_pkg::SlotW'(1);
      end
      if (load) begin
        sval <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (sval || load)) begin
      bundle <= sval ? spare : bundle_in;
    end
    if (load && !advance) begin
      spare <= bundle_in;
    end
  end

  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    bval |-> bundle.count != '0)
    else $error("held bundle is empty");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !sval)
    else $error("bundle loaded over pending results");

  a_spare_behind_active: assert property (@(posedge clk) disable iff (rst)
    sval |-> bval)
    else $error("spare bundle held with no active bundle");

  a_status_closes_run: assert property (@(posedge clk) disable iff (rst)
    bval && kind != b64d_pkg::KIND_DATA |-> last_of_run)
    else $error("end status is not the final result of its request");

endmodule

`default_nettype wire

[rtl/base64_stream_decoder_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Streaming Base64 decoder, one ASCII character per request. Each character
// is decoded in the cycle it is taken and its results (up to three bytes,
// then an end status on the character marked is_last) go to a result
// register that hands out one result per cycle while the output is not stalled, the first in
// the cycle after the request when the output is idle. A spare register holds the results of
// the next character that gives any while the current set drains, so the
// input stalls only while that spare is full; it reopens the cycle after the
// last result of the current set is taken. A steady stream of groups runs at
// one character per cycle, since four characters give at most three bytes;
// output stalls or closely spaced end statuses can fill the spare and stall
// the input. Line breaks and trailing spaces are skipped, and after an error
// no bytes go out until the end status.
module base64_stream_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       is_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      data_byte,
  output logic            last_of_run
);

  b64d_pkg::bundle_t bundle;
  logic              free;
  logic              accept;
  logic              load;

  assign in_stall = !free;
  assign accept   = in_valid && free;
  assign load     = accept && bundle.count != '0;

  b64d_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_char (in_char),
    .is_last (is_last),
    .bundle  (bundle)
  );

  b64d_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .bundle_in   (bundle),
    .free        (free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .data_byte   (data_byte),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
